@@ design/lsb_se_pkg.sv @@
// Shared constants for the LSB stego extractor: register indexes, reset values, codes.
`default_nettype none
package lsb_se_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_ROW_DATA_BYTES = 2'd0;
  localparam logic [1:0] REG_ROW_PADDING    = 2'd1;
  localparam logic [1:0] REG_XOR_KEY        = 2'd2;

  // reset values of the configuration registers
  localparam logic [15:0] ROW_DATA_BYTES_RST = 16'd4;
  localparam logic [1:0]  ROW_PADDING_RST    = 2'd0;
  localparam logic [7:0]  XOR_KEY_RST        = 8'h5A;  // 'Z'

  // framing phase codes; anything at or above PH_DONE acts as done
  localparam logic [2:0] PH_LEN  = 3'd0;
  localparam logic [2:0] PH_NAME = 3'd1;
  localparam logic [2:0] PH_SIZE = 3'd2;
  localparam logic [2:0] PH_PAY  = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;

  // section tags on the result
  typedef logic [1:0] section_t;
  localparam section_t SEC_NAME_LEN  = 2'd0;
  localparam section_t SEC_NAME_CHAR = 2'd1;
  localparam section_t SEC_SIZE      = 2'd2;
  localparam section_t SEC_PAYLOAD   = 2'd3;

  localparam logic [1:0] SIZE_LAST_INDEX = 2'd3;

endpackage
`default_nettype wire

@@ design/lsb_stego_extractor_top.sv @@
// LSB stego extractor top level: row/padding tracking, bit gathering and framing.
`default_nettype none
// Usage:
//   Input channel (in_valid/in_ready) carries one pixel byte per beat, starting
//   at the first pixel-data byte, plus a restart flag that clears row, gather
//   and framing state before that byte is used.
//   Output channel (out_valid/out_ready) carries one decoded byte per beat with
//   its section tag (name length, name char, size byte, payload) and a
//   last_payload flag on the final payload byte, or on the fourth size byte
//   when the size is zero. Only every eighth used data byte yields a beat;
//   padding bytes and bytes seen after the done phase yield none.
//   Config channel (cfg_valid/cfg_ready) writes row_data_bytes (index 0),
//   row_padding (index 1) and xor_key (index 2); other indexes are dropped.
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   One pixel byte per cycle sustained. All state updates at the accepting
//   edge, which also loads the result into the output register.
//   The output register is the only buffer: while a result waits and the
//   receiver stalls, in_ready drops; it is high whenever the register is
//   empty or being drained in the same cycle.
// Reset: rst (synchronous) clears all framing state, drops out_valid and
//   loads the register defaults 4, 0 and 0x5A.
module lsb_stego_extractor_top
  import lsb_se_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  pixel_byte,
  input  wire logic        restart,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       decoded_byte,
  output logic [1:0]       section,
  output logic             last_payload,
  // config channel
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] row_data_bytes;
  logic [1:0]  row_padding;
  logic [7:0]  xor_key;

  // block state
  logic [2:0]  phase;
  logic [2:0]  bit_count;
  logic [7:0]  gather_reg;
  logic [15:0] row_count;
  logic [1:0]  pad_count;
  logic [7:0]  name_left;
  logic [31:0] size_accum;
  logic [31:0] payload_left;
  logic [1:0]  size_index;

  logic [2:0]  phase_next;
  logic [2:0]  bit_count_next;
  logic [7:0]  gather_reg_next;
  logic [15:0] row_count_next;
  logic [1:0]  pad_count_next;
  logic [7:0]  name_left_next;
  logic [31:0] size_accum_next;
  logic [31:0] payload_left_next;
  logic [1:0]  size_index_next;

  // state as seen by this beat, after an optional restart
  logic [2:0]  ph_cur;
  logic [2:0]  bc_cur;
  logic [7:0]  gr_cur;
  logic [15:0] rc_cur;
  logic [1:0]  pc_cur;
  logic [7:0]  nl_cur;
  logic [31:0] sa_cur;
  logic [31:0] pl_cur;
  logic [1:0]  si_cur;

  logic        row_full;
  logic [2:0]  pad_inc;
  logic [7:0]  gathered;
  logic [7:0]  dec_byte;
  logic [7:0]  nl_dec;
  logic [31:0] pl_dec;
  logic [31:0] sa_merged;

  logic        res_valid;
  logic [7:0]  res_byte;
  section_t    res_section;
  logic        res_last;

  logic        in_beat;

  assign in_ready  = !out_valid || out_ready;
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    ph_cur = restart ? PH_LEN : phase;
    bc_cur = restart ? 3'd0   : bit_count;
    gr_cur = restart ? 8'd0   : gather_reg;
    rc_cur = restart ? 16'd0  : row_count;
    pc_cur = restart ? 2'd0   : pad_count;
    nl_cur = restart ? 8'd0   : name_left;
    sa_cur = restart ? 32'd0  : size_accum;
    pl_cur = restart ? 32'd0  : payload_left;
    si_cur = restart ? 2'd0   : size_index;

    phase_next        = ph_cur;
    bit_count_next    = bc_cur;
    gather_reg_next   = gr_cur;
    row_count_next    = rc_cur;
    pad_count_next    = pc_cur;
    name_left_next    = nl_cur;
    size_accum_next   = sa_cur;
    payload_left_next = pl_cur;
    size_index_next   = si_cur;

    // zero row length never matches a full row
    row_full  = (row_data_bytes != 16'd0) && (rc_cur == row_data_bytes);
    pad_inc   = {1'b0, pc_cur} + 3'd1;
    gathered  = {gr_cur[6:0], pixel_byte[0]};
    dec_byte  = gathered ^ xor_key;
    nl_dec    = nl_cur - 8'd1;
    pl_dec    = pl_cur - 32'd1;

    sa_merged = sa_cur;
    case (si_cur)
      2'd0:    sa_merged = sa_cur | {24'd0, dec_byte};
      2'd1:    sa_merged = sa_cur | {16'd0, dec_byte, 8'd0};
      2'd2:    sa_merged = sa_cur | {8'd0, dec_byte, 16'd0};
      default: sa_merged = sa_cur | {dec_byte, 24'd0};
    endcase

    res_valid   = 1'b0;
    res_byte    = dec_byte;
    res_section = SEC_PAYLOAD;
    res_last    = 1'b0;

    if (ph_cur < PH_DONE) begin
      if (row_full && (row_padding != 2'd0)) begin
        // padding byte: skip
        if (pad_inc >= {1'b0, row_padding}) begin
          pad_count_next = 2'd0;
          row_count_next = 16'd0;
        end else begin
          pad_count_next = pad_inc[1:0];
        end
      end else begin
        row_count_next  = (row_full ? 16'd0 : rc_cur) + 16'd1;
        gather_reg_next = gathered;
        bit_count_next  = bc_cur + 3'd1;
        if (bc_cur == 3'd7) begin
          res_valid = 1'b1;
          unique case (ph_cur)
            PH_LEN: begin
              res_section    = SEC_NAME_LEN;
              name_left_next = dec_byte;
              phase_next     = (dec_byte == 8'd0) ? PH_SIZE : PH_NAME;
            end
            PH_NAME: begin
              res_section    = SEC_NAME_CHAR;
              name_left_next = nl_dec;
              if (nl_dec == 8'd0) phase_next = PH_SIZE;
            end
            PH_SIZE: begin
              res_section     = SEC_SIZE;
              size_accum_next = sa_merged;
              if (si_cur == SIZE_LAST_INDEX) begin
                size_index_next   = 2'd0;
                payload_left_next = sa_merged;
                if (sa_merged == 32'd0) begin
                  res_last   = 1'b1;
                  phase_next = PH_DONE;
                end else begin
                  phase_next = PH_PAY;
                end
              end else begin
                size_index_next = si_cur + 2'd1;
              end
            end
            default: begin
              res_section       = SEC_PAYLOAD;
              payload_left_next = pl_dec;
              if (pl_dec == 32'd0) begin
                res_last   = 1'b1;
                phase_next = PH_DONE;
              end
            end
          endcase
        end
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_data_bytes <= ROW_DATA_BYTES_RST;
      row_padding    <= ROW_PADDING_RST;
      xor_key        <= XOR_KEY_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_DATA_BYTES: row_data_bytes <= cfg_data;
        REG_ROW_PADDING:    row_padding    <= cfg_data[1:0];
        REG_XOR_KEY:        xor_key        <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // block state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEN;
      bit_count    <= 3'd0;
      gather_reg   <= 8'd0;
      row_count    <= 16'd0;
      pad_count    <= 2'd0;
      name_left    <= 8'd0;
      size_accum   <= 32'd0;
      payload_left <= 32'd0;
      size_index   <= 2'd0;
    end else if (in_beat) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      gather_reg   <= gather_reg_next;
      row_count    <= row_count_next;
      pad_count    <= pad_count_next;
      name_left    <= name_left_next;
      size_accum   <= size_accum_next;
      payload_left <= payload_left_next;
      size_index   <= size_index_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_beat) begin
      out_valid <= res_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat && res_valid) begin
      decoded_byte <= res_byte;
      section      <= res_section;
      last_payload <= res_last;
    end
  end

endmodule
`default_nettype wire

@@ bench/tb_lsb_stego_extractor_top.sv @@
// Self-checking bench for the LSB stego extractor: hidden-file streams, reg changes, back-pressure.
import lsb_se_pkg::*;

class decode_scoreboard;
  typedef struct packed {
    logic [7:0] value;
    section_t   sec;
    logic       last;
  } decoded_t;

  // register copies
  logic [15:0] row_len;
  logic [1:0]  pad_len;
  logic [7:0]  key;

  // extraction state
  logic [2:0]  phase;
  logic [2:0]  bit_cnt;
  logic [7:0]  gather;
  logic [15:0] row_pos;
  logic [1:0]  pad_seen;
  logic [7:0]  name_left;
  logic [31:0] size_acc;
  logic [31:0] pay_left;
  logic [1:0]  size_idx;

  decoded_t decoded_q[$];
  int       errors;

  function new();
    errors  = 0;
    row_len = ROW_DATA_BYTES_RST;
    pad_len = ROW_PADDING_RST;
    key     = XOR_KEY_RST;
    clear_frame();
  endfunction

  function void clear_frame();
    phase     = PH_LEN;
    bit_cnt   = '0;
    gather    = '0;
    row_pos   = '0;
    pad_seen  = '0;
    name_left = '0;
    size_acc  = '0;
    pay_left  = '0;
    size_idx  = '0;
  endfunction

  function void apply_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      REG_ROW_DATA_BYTES: row_len = data;
      REG_ROW_PADDING:    pad_len = data[1:0];
      REG_XOR_KEY:        key     = data[7:0];
      default: ;
    endcase
  endfunction

  // true when the next byte (without restart) lands in row padding
  function bit pad_next();
    return phase < PH_DONE && row_len != 0 && row_pos == row_len && pad_len != 0;
  endfunction

  function int pending();
    return decoded_q.size();
  endfunction

  function void note_carrier(logic [7:0] cb, logic rs);
    logic [2:0] np;
    logic [7:0] b;
    section_t   sec;
    logic       last;
    decoded_t   d;
    if (rs) clear_frame();
    if (phase >= PH_DONE) return;
    if (row_len != 0 && row_pos == row_len) begin
      if (pad_len != 0) begin
        np = {1'b0, pad_seen} + 3'd1;
        if (np >= {1'b0, pad_len}) begin
          pad_seen = '0;
          row_pos  = '0;
        end else begin
          pad_seen = np[1:0];
        end
        return;
      end
      row_pos = '0;
    end
    row_pos = row_pos + 16'd1;
    gather  = {gather[6:0], cb[0]};
    bit_cnt = bit_cnt + 3'd1;
    if (bit_cnt != 0) return;
    b    = gather ^ key;
    last = 1'b0;
    case (phase)
      PH_LEN: begin
        sec       = SEC_NAME_LEN;
        name_left = b;
        phase     = (b == 0) ? PH_SIZE : PH_NAME;
      end
      PH_NAME: begin
        sec       = SEC_NAME_CHAR;
        name_left = name_left - 8'd1;
        if (name_left == 0) phase = PH_SIZE;
      end
      PH_SIZE: begin
        sec      = SEC_SIZE;
        size_acc = size_acc | ({24'd0, b} << (8 * size_idx));
        if (size_idx == SIZE_LAST_INDEX) begin
          size_idx = '0;
          pay_left = size_acc;
          if (pay_left == 0) begin
            last  = 1'b1;
            phase = PH_DONE;
          end else begin
            phase = PH_PAY;
          end
        end else begin
          size_idx = size_idx + 2'd1;
        end
      end
      default: begin
        sec      = SEC_PAYLOAD;
        pay_left = pay_left - 32'd1;
        if (pay_left == 0) begin
          last  = 1'b1;
          phase = PH_DONE;
        end
      end
    endcase
    d.value = b;
    d.sec   = sec;
    d.last  = last;
    decoded_q.push_back(d);
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task check_decoded(logic [7:0] value, logic [1:0] sec, logic last);
    decoded_t e;
    if (decoded_q.size() == 0) begin
      report($sformatf("unexpected beat byte=%02h section=%0d last=%0b", value, sec, last));
      return;
    end
    e = decoded_q.pop_front();
    if (value !== e.value)
      report($sformatf("decoded_byte %02h, want %02h", value, e.value));
    if (sec !== e.sec)
      report($sformatf("section %0d, want %0d (byte %02h)", sec, e.sec, e.value));
    if (last !== e.last)
      report($sformatf("last_payload %0b, want %0b (byte %02h)", last, e.last, e.value));
  endtask
endclass

module tb_lsb_stego_extractor_top;
  import lsb_se_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;   // no register here; write must be dropped
  localparam int DRAIN_CYCLES = 4;            // drain margin for a byte still in the output register
  localparam int RANDOM_BEATS = 750;
  localparam int HOLD_CYCLES  = 80;

  typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel_byte;
  logic        restart;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  decoded_byte;
  logic [1:0]  section;
  logic        last_payload;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  decode_scoreboard sb;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;     // receiver hold-off, counted down by the receiver process
  int live_beats;    // beats that the block actually acts on
  bit hidden_bits[$];  // hidden-file bits still to embed, first bit first

  lsb_stego_extractor_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .pixel_byte   (pixel_byte),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .decoded_byte (decoded_byte),
    .section      (section),
    .last_payload (last_payload),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic set_idle(input idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 72; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default:   begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  // One input beat. Entered and left at a falling edge; valid stays high on
  // return so back-to-back beats never toggle it within one time step.
  task automatic send_beat(input logic [7:0] cb, input logic rs);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    pixel_byte <= cb;
    restart    <= rs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (rs || sb.phase < PH_DONE) live_beats++;
    sb.note_carrier(cb, rs);
    @(negedge clk);
  endtask

  // Embed one hidden byte: key applied so that the block's XOR recovers m.
  task automatic queue_byte(input logic [7:0] m);
    logic [7:0] g;
    g = m ^ sb.key;
    for (int i = 7; i >= 0; i--) hidden_bits.push_back(g[i]);
  endtask

  // Name length, name, 4 size bytes LSB first, payload. A fill below zero means random.
  task automatic queue_file(input int len, input int pay_len, input int name_fill,
                            input int pay_fill);
    hidden_bits.delete();
    queue_byte(8'(len));
    for (int i = 0; i < len; i++)
      queue_byte(name_fill < 0 ? 8'($urandom) : 8'(name_fill));
    for (int i = 0; i < 4; i++) queue_byte(8'(pay_len >> (8 * i)));
    for (int i = 0; i < pay_len; i++)
      queue_byte(pay_fill < 0 ? 8'($urandom) : 8'(pay_fill));
  endtask

  // Send up to n beats (n < 0: until the hidden bits run out). Padding beats
  // get random content wherever the row layout calls for them.
  task automatic send_beats(input int n, input logic rs_first);
    int   sent;
    logic rs;
    sent = 0;
    rs   = rs_first;
    while (hidden_bits.size() > 0 && (n < 0 || sent < n)) begin
      if (!rs && sb.pad_next())
        send_beat(8'($urandom), 1'b0);
      else
        send_beat({7'($urandom), hidden_bits.pop_front()}, rs);
      rs = 1'b0;
      sent++;
    end
  endtask

  task automatic send_noise(input int n, input int restart_pct);
    for (int i = 0; i < n; i++)
      send_beat(8'($urandom), $urandom_range(0, 99) < restart_pct);
  endtask

  // Block idle: no beat pending, plus a drain margin for a byte still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_config();
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 70)
      write_cfg(REG_ROW_DATA_BYTES,
                r < 4  ? 16'd0 :
                r < 10 ? 16'hFFFF :
                r < 15 ? 16'($urandom) : 16'($urandom_range(1, 12)));
    if ($urandom_range(0, 99) < 70)
      write_cfg(REG_ROW_PADDING, 16'($urandom_range(0, 3)));
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 70)
      write_cfg(REG_XOR_KEY, r < 10 ? 16'h0000 : r < 20 ? 16'h00FF : 16'($urandom_range(0, 255)));
  endtask

  // Receiver: random stalls, or a long counted hold-off when asked for.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Output beats are taken on the rising edge, before any register updates.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_decoded(decoded_byte, section, last_payload);
  end

  initial begin
    int file_no;
    int kind;
    int goal;
    int len;
    int pay_len;
    sb           = new();
    rst          = 1'b1;
    in_valid     = 1'b0;
    pixel_byte   = '0;
    restart      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_ROW_DATA_BYTES;
    cfg_data     = '0;
    hold_left    = 0;
    live_beats   = 0;
    set_idle(IDLE_BOTH);
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // Reset registers; empty name and zero size, so last_payload rides the
    // fourth size byte. Trailing bytes fall in the done phase.
    queue_file(0, 0, -1, -1);
    send_beats(-1, 1'b1);
    send_noise(3, 0);

    // One data byte per row, widest padding, zero key; all-ones name char.
    wait_idle();
    write_cfg(REG_ROW_DATA_BYTES, 16'd1);
    write_cfg(REG_ROW_PADDING, 16'd3);
    write_cfg(REG_XOR_KEY, 16'h0000);
    queue_file(1, 1, 8'hFF, 8'h00);
    send_beats(-1, 1'b1);

    // Longest row, no padding, all-ones key.
    wait_idle();
    write_cfg(REG_ROW_DATA_BYTES, 16'hFFFF);
    write_cfg(REG_ROW_PADDING, 16'd0);
    write_cfg(REG_XOR_KEY, 16'h00FF);
    queue_file(2, 2, 8'h00, 8'hFF);
    send_beats(-1, 1'b1);

    // Zero row length: the row never fills, padding never skipped.
    wait_idle();
    write_cfg(REG_ROW_DATA_BYTES, 16'd0);
    write_cfg(REG_ROW_PADDING, 16'd2);
    write_cfg(REG_XOR_KEY, 16'h00A5);
    queue_file(0, 1, -1, -1);
    send_beats(-1, 1'b1);

    // Row length cut below the current row position mid-row.
    wait_idle();
    write_cfg(REG_ROW_DATA_BYTES, 16'd6);
    queue_file(1, 1, -1, -1);
    send_beats(5, 1'b1);
    wait_idle();
    write_cfg(REG_ROW_DATA_BYTES, 16'd3);
    send_beats(-1, 1'b0);

    // Padding lowered after one padding byte was already skipped.
    wait_idle();
    write_cfg(REG_ROW_DATA_BYTES, 16'd2);
    write_cfg(REG_ROW_PADDING, 16'd3);
    queue_file(0, 0, -1, -1);
    send_beats(3, 1'b1);
    wait_idle();
    write_cfg(REG_ROW_PADDING, 16'd1);
    send_beats(-1, 1'b0);

    // Dropped index; longest name cut short by restart, then restart again
    // in the middle of a gathered byte.
    wait_idle();
    write_cfg(REG_UNUSED, 16'hFFFF);
    write_cfg(REG_ROW_DATA_BYTES, 16'd4);
    write_cfg(REG_ROW_PADDING, 16'd1);
    write_cfg(REG_XOR_KEY, 16'h005A);
    hidden_bits.delete();
    queue_byte(8'hFF);
    queue_byte(8'($urandom));
    queue_byte(8'($urandom));
    send_beats(-1, 1'b1);
    queue_file(3, 2, -1, -1);
    send_beats(5, 1'b1);

    // --- random ---
    // Mostly well-formed files with random content; idling mode rotates per
    // file. Files 4, 12, ... run flat out while the receiver holds off, so
    // the output register fills and in_ready must drop.
    goal    = live_beats + RANDOM_BEATS;
    file_no = 0;
    while (live_beats < goal) begin
      set_idle(idle_mode_t'(file_no % 4));
      if ($urandom_range(0, 99) < 35) begin
        wait_idle();
        random_config();
      end
      if (file_no % 8 == 4) hold_left = HOLD_CYCLES;
      kind = $urandom_range(0, 99);
      if (kind < 78) begin
        len     = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 5);
        pay_len = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 10);
        queue_file(len, pay_len, -1, -1);
        send_beats(-1, 1'b1);
        send_noise($urandom_range(0, 3), 0);
      end else if (kind < 90) begin
        // truncated file; the next file's restart cuts it off
        queue_file($urandom_range(0, 8), $urandom_range(0, 20), -1, -1);
        send_beats($urandom_range(1, hidden_bits.size() - 1), 1'b1);
      end else begin
        send_noise($urandom_range(16, 64), 8);
      end
      file_no++;
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
design/lsb_se_pkg.sv
design/lsb_stego_extractor_top.sv
bench/tb_lsb_stego_extractor_top.sv
